[hdl/upq_pkg.sv]
// upq_pkg: shared types, codes and size constants for the unique priority queue engine
// used by the core, the compare unit and the port checker; no dependencies
package upq_pkg;

  localparam int TAG_BITS     = 32;
  localparam int PRIO_BITS    = 16;
  localparam int CAPACITY_DEF = 16;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int CNT_OUT_W    = $clog2(CAPACITY_DEF + 1);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTAG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 change_mode;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio_value;
    logic [PRIO_BITS-1:0] prio_upper;
  } upq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TAG_BITS-1:0]  tag_out;
    logic [PRIO_BITS-1:0] prio_out;
    logic [CNT_OUT_W-1:0] removed_count;
    logic [CNT_OUT_W-1:0] fill_level;
    logic                 table_empty;
  } upq_out_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // flags from the shared compare unit for one table entry
  typedef struct packed {
    logic tag_eq;
    logic prio_eq;
    logic prio_gt;
    logic in_range;
  } cmp_t;

endpackage

[hdl/upq_ram.sv]
// upq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module upq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/upq_cmp.sv]
// upq_cmp: shared compare unit, checks one table entry against the current command
// depends on upq_pkg
module upq_cmp (
  input  upq_pkg::entry_t                  entry,
  input  logic [upq_pkg::TAG_BITS-1:0]     tag,
  input  logic [upq_pkg::PRIO_BITS-1:0]    prio_lo,
  input  logic [upq_pkg::PRIO_BITS-1:0]    prio_hi,
  output upq_pkg::cmp_t                    flags
);
  import upq_pkg::*;

  always_comb begin
    flags.tag_eq   = (entry.tag == tag);
    flags.prio_eq  = (entry.prio == prio_lo);
    flags.prio_gt  = (entry.prio > prio_lo);
    flags.in_range = (entry.prio >= prio_lo) && (entry.prio <= prio_hi);
  end

endmodule

[hdl/unique_priority_queue_engine_core.sv]
// unique_priority_queue_engine_core: top level, sequencer around the entry RAM
// depends on upq_pkg, upq_ram, upq_cmp
//
// The table is held in one RAM, ordered from highest to lowest priority, and every
// command but clear and the unused codes walks it through the single read port, one
// entry a cycle, with one shared compare unit. Peek, lookup, a dequeue on an empty
// table and rejected enqueues or changes do a scan only; any other dequeue does a
// scan, then a compaction pass; range removal a compaction pass only; an enqueue a
// scan, then an upward shift from the insert point; a priority change a scan, a
// removal pass and an insert shift; clear and the unused codes go straight to the
// result. busy stays high from accept until the result is out, and start is only
// taken while busy is low. The result is shown for exactly one cycle with done high;
// there is no back-pressure, so the receiver must take it then.
module unique_priority_queue_engine_core #(
  parameter int CAPACITY = upq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  upq_pkg::upq_in_t  cmd,
  output logic              busy,
  output logic              done,
  output upq_pkg::upq_out_t result
);
  import upq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FILTER, S_INSERT, S_DONE} state_t;

  state_t               state;
  upq_in_t              op;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rd_idx;
  logic [CNT_W-1:0]     wr_idx;
  logic [CNT_W-1:0]     removed;
  logic [CNT_W-1:0]     gt_cnt;
  logic [CNT_W-1:0]     ins_pos;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic [IDX_W-1:0]     drop_idx;
  logic [IDX_W-1:0]     hit_idx;
  logic [1:0]           hits;
  logic                 found;
  logic                 taken;
  logic                 hit_gt;
  logic                 ins_after;
  logic [PRIO_BITS-1:0] hit_prio;
  logic [TAG_BITS-1:0]  head_tag;
  logic [PRIO_BITS-1:0] head_prio;
  logic [STATUS_W-1:0]  status;
  logic [TAG_BITS-1:0]  tag_o;
  logic [PRIO_BITS-1:0] prio_o;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t                rd_entry;
  cmp_t                  flags;
  logic                  issue;
  logic                  range_mode;
  logic                  drop;
  logic [CNT_W-1:0]      rd_dec;

  upq_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  upq_cmp u_cmp (
    .entry  (rd_entry),
    .tag    (op.tag),
    .prio_lo(op.prio_value),
    .prio_hi(op.prio_upper),
    .flags  (flags)
  );

  assign busy       = (state != S_IDLE);
  assign range_mode = (op.kind == KIND_RANGE);
  assign drop       = range_mode ? flags.in_range : (pend_idx == drop_idx);
  assign rd_dec     = rd_idx - 1'b1;

  // read issue and write port steering
  always_comb begin
    issue     = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {op.tag, op.prio_value};
    unique case (state)
      S_SCAN: begin
        if (rd_idx < count) begin
          issue     = 1'b1;
          ram_raddr = rd_idx[IDX_W-1:0];
        end
      end
      S_FILTER: begin
        if (rd_idx < count) begin
          issue     = 1'b1;
          ram_raddr = rd_idx[IDX_W-1:0];
        end
        // compaction: kept entries slide down, writes never pass the read pointer
        if (pend && !drop) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
      end
      S_INSERT: begin
        if (rd_idx > ins_pos) begin
          issue     = 1'b1;
          ram_raddr = rd_dec[IDX_W-1:0];
        end
        // shift up from the top, then drop the new entry into the gap
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx + 1'b1;
          ram_wdata = ram_rdata;
        end else if (!issue) begin
          ram_we    = 1'b1;
          ram_waddr = ins_pos[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= issue;
      if (issue) begin
        pend_idx <= ram_raddr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= cmd;
            status    <= ST_DONE;
            tag_o     <= '0;
            prio_o    <= '0;
            removed   <= '0;
            hits      <= '0;
            found     <= 1'b0;
            taken     <= 1'b0;
            gt_cnt    <= '0;
            rd_idx    <= '0;
            wr_idx    <= '0;
            ins_after <= 1'b0;
            drop_idx  <= '0;
            unique case (cmd.kind) inside
              KIND_ENQ, KIND_DEQ, KIND_PEEK, KIND_LOOKUP: state <= S_SCAN;
              KIND_RANGE: state <= S_FILTER;
              KIND_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pend) begin
            if (pend_idx == '0) begin
              head_tag  <= rd_entry.tag;
              head_prio <= rd_entry.prio;
            end
            if (flags.prio_eq) begin
              taken <= 1'b1;
            end
            if (flags.prio_gt) begin
              gt_cnt <= gt_cnt + 1'b1;
            end
            if (flags.tag_eq) begin
              if (hits != 2'd2) begin
                hits <= hits + 2'd1;
              end
              hit_idx <= pend_idx;
              hit_gt  <= flags.prio_gt;
              // lookup answers with the hit nearest the head
              if (!found) begin
                found    <= 1'b1;
                hit_prio <= rd_entry.prio;
              end
            end
          end else if (!issue) begin
            rd_idx <= '0;
            state  <= S_DONE;
            unique case (op.kind) inside
              KIND_ENQ: begin
                if (op.change_mode) begin
                  if (hits != 2'd1) begin
                    status <= ST_NOTAG;
                  end else if (taken) begin
                    status <= ST_TAKEN;
                  end else begin
                    // removed entry sat above the insert point if its priority was higher
                    drop_idx  <= hit_idx;
                    ins_after <= 1'b1;
                    ins_pos   <= gt_cnt - CNT_W'(hit_gt);
                    state     <= S_FILTER;
                  end
                end else if (taken) begin
                  status <= ST_TAKEN;
                end else if (count == CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                end else begin
                  ins_pos <= gt_cnt;
                  rd_idx  <= count;
                  state   <= S_INSERT;
                end
              end
              KIND_DEQ, KIND_PEEK: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  tag_o  <= head_tag;
                  prio_o <= head_prio;
                  if (op.kind == KIND_DEQ) begin
                    drop_idx <= '0;
                    state    <= S_FILTER;
                  end
                end
              end
              KIND_LOOKUP: begin
                if (found) begin
                  prio_o <= hit_prio;
                end else begin
                  status <= ST_NOTAG;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILTER: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pend) begin
            if (!drop) begin
              wr_idx <= wr_idx + 1'b1;
            end else if (range_mode) begin
              removed <= removed + 1'b1;
            end
          end else if (!issue) begin
            count <= wr_idx;
            if (ins_after) begin
              rd_idx <= wr_idx;
              state  <= S_INSERT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_INSERT: begin
          if (issue) begin
            rd_idx <= rd_dec;
          end
          if (!pend && !issue) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done                 <= 1'b1;
          result.status        <= status;
          result.tag_out       <= tag_o;
          result.prio_out      <= prio_o;
          result.removed_count <= CNT_OUT_W'(removed);
          result.fill_level    <= CNT_OUT_W'(count);
          result.table_empty   <= (count == '0);
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/upq_checker.sv]
// upq_checker: port-level assertions for the unique priority queue engine, with bind
// depends on upq_pkg and unique_priority_queue_engine_core
module upq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input upq_pkg::upq_out_t result
);
  import upq_pkg::*;

  // an accepted command always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // one result per command, never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // the block frees up exactly when its result comes out
  a_free_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  // an empty-table answer carries no head entry
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_EMPTY) |->
      (result.tag_out == '0) && (result.prio_out == '0) && result.table_empty)
    else $error("empty status with head data or non-empty table");

endmodule

bind unique_priority_queue_engine_core upq_checker u_upq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

[test/testbench.sv]
// testbench for unique_priority_queue_engine_core: directed and random command beats,
// results checked against an in-bench model of the ordered table
// depends on upq_pkg and the core rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import upq_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1525;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam int NO_IDLE_FROM = 500;
  localparam int NO_IDLE_TO = 800;
  localparam logic [KIND_W-1:0] KIND_NOP_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP_B = 3'd7;

  typedef enum int {
    MIX_ENQ, MIX_CHG, MIX_DEQ, MIX_PEEK, MIX_LOOKUP, MIX_RANGE, MIX_CLEAR, MIX_NOP
  } mix_slot_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_t;

  typedef struct {
    upq_in_t op;
    bit      hold_for_drain;
  } backlog_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  upq_in_t  cmd = '0;
  logic     busy;
  logic     done;
  upq_out_t result;

  unique_priority_queue_engine_core #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  backlog_t cmd_backlog[$];
  upq_out_t predicted_results[$];
  bit       offer_live = 1'b0;
  int       beats_sent = 0;
  int       errors = 0;
  int       quiet_cycles = 0;

  // model of the table, head at slot 0
  logic [TAG_BITS-1:0]  held_tag[CAPACITY];
  logic [PRIO_BITS-1:0] held_prio[CAPACITY];
  int                   held_count = 0;

  logic [TAG_BITS-1:0]  tag_pool[20];
  logic [PRIO_BITS-1:0] prio_pool[28];
  int                   op_mix[3][8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit prio_held(logic [PRIO_BITS-1:0] p);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < held_count; i++) if (held_prio[i] == p) hit = 1'b1;
    return hit;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_tag[i]  = held_tag[i+1];
      held_prio[i] = held_prio[i+1];
    end
    held_count--;
  endfunction

  function automatic void place_entry(logic [TAG_BITS-1:0] t, logic [PRIO_BITS-1:0] p);
    int pos;
    pos = 0;
    while (pos < held_count && held_prio[pos] > p) pos++;
    for (int i = held_count; i > pos; i--) begin
      held_tag[i]  = held_tag[i-1];
      held_prio[i] = held_prio[i-1];
    end
    held_tag[pos]  = t;
    held_prio[pos] = p;
    held_count++;
  endfunction

  // applies one command to the model table and returns the result it should give
  function automatic upq_out_t serve_op(upq_in_t op);
    upq_out_t r;
    int       hits;
    int       at;
    int       idx;
    bit       found;
    r = '0;
    r.status = ST_DONE;
    case (op.kind)
      KIND_ENQ: begin
        if (op.change_mode) begin
          hits = 0;
          at = 0;
          for (int i = 0; i < held_count; i++) begin
            if (held_tag[i] == op.tag) begin
              hits++;
              at = i;
            end
          end
          if (hits != 1) r.status = ST_NOTAG;
          else if (prio_held(op.prio_value)) r.status = ST_TAKEN;
          else begin
            drop_slot(at);
            place_entry(op.tag, op.prio_value);
          end
        end else begin
          // a taken priority wins over a full table
          if (prio_held(op.prio_value)) r.status = ST_TAKEN;
          else if (held_count >= CAPACITY) r.status = ST_FULL;
          else place_entry(op.tag, op.prio_value);
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else begin
          r.tag_out  = held_tag[0];
          r.prio_out = held_prio[0];
          if (op.kind == KIND_DEQ) drop_slot(0);
        end
      end
      KIND_LOOKUP: begin
        found = 1'b0;
        r.status = ST_NOTAG;
        for (int i = 0; i < held_count; i++) begin
          if (!found && held_tag[i] == op.tag) begin
            found = 1'b1;
            r.status = ST_DONE;
            r.prio_out = held_prio[i];
          end
        end
      end
      KIND_RANGE: begin
        idx = 0;
        while (idx < held_count) begin
          if (held_prio[idx] >= op.prio_value && held_prio[idx] <= op.prio_upper) begin
            drop_slot(idx);
            r.removed_count++;
          end else begin
            idx++;
          end
        end
      end
      KIND_CLEAR: held_count = 0;
      default: ;
    endcase
    r.fill_level = held_count[CNT_OUT_W-1:0];
    r.table_empty = (held_count == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_op(logic [KIND_W-1:0] kind, logic chg,
                                   logic [TAG_BITS-1:0] t, logic [PRIO_BITS-1:0] pv,
                                   logic [PRIO_BITS-1:0] pu, bit drain);
    backlog_t b;
    b.op.kind = kind;
    b.op.change_mode = chg;
    b.op.tag = t;
    b.op.prio_value = pv;
    b.op.prio_upper = pu;
    b.hold_for_drain = drain;
    cmd_backlog.push_back(b);
  endfunction

  function automatic logic [TAG_BITS-1:0] pick_tag();
    if ($urandom_range(0, 99) < 85) return tag_pool[$urandom_range(0, 19)];
    return TAG_BITS'($urandom);
  endfunction

  function automatic logic [PRIO_BITS-1:0] pick_prio();
    if ($urandom_range(0, 99) < 80) return prio_pool[$urandom_range(0, 27)];
    return PRIO_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_random_op(mix_mode_t mode, bit drain);
    int                   roll;
    int                   acc;
    mix_slot_t            slot;
    logic [PRIO_BITS-1:0] lo;
    logic [PRIO_BITS-1:0] hi;
    logic                 noise;
    roll = $urandom_range(0, 99);
    acc = 0;
    slot = MIX_NOP;
    for (int s = 0; s < 8; s++) begin
      if (roll >= acc && roll < acc + op_mix[int'(mode)][s]) slot = mix_slot_t'(s);
      acc += op_mix[int'(mode)][s];
    end
    lo = pick_prio();
    hi = pick_prio();
    // bounds mostly in order, sometimes reversed
    if (lo > hi && $urandom_range(0, 99) < 70) begin
      lo = lo ^ hi;
      hi = lo ^ hi;
      lo = lo ^ hi;
    end
    noise = 1'($urandom_range(0, 1));
    case (slot)
      MIX_ENQ:    queue_op(KIND_ENQ, 1'b0, pick_tag(), lo, hi, drain);
      MIX_CHG:    queue_op(KIND_ENQ, 1'b1, pick_tag(), lo, hi, drain);
      MIX_DEQ:    queue_op(KIND_DEQ, noise, pick_tag(), lo, hi, drain);
      MIX_PEEK:   queue_op(KIND_PEEK, noise, pick_tag(), lo, hi, drain);
      MIX_LOOKUP: queue_op(KIND_LOOKUP, noise, pick_tag(), lo, hi, drain);
      MIX_RANGE:  queue_op(KIND_RANGE, noise, pick_tag(), lo, hi, drain);
      MIX_CLEAR:  queue_op(KIND_CLEAR, noise, pick_tag(), lo, hi, drain);
      default: queue_op(noise ? KIND_NOP_A : KIND_NOP_B, 1'($urandom_range(0, 1)),
                        pick_tag(), lo, hi, drain);
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    mix_mode_t mode;
    op_mix[MODE_FILL]  = '{70, 8, 6, 4, 6, 3, 1, 2};
    op_mix[MODE_DRAIN] = '{20, 8, 40, 8, 10, 10, 2, 2};
    op_mix[MODE_MIXED] = '{40, 15, 15, 8, 10, 8, 2, 2};
    foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom);
    foreach (prio_pool[i]) prio_pool[i] = PRIO_BITS'($urandom_range(0, 65535));

    // empty table
    queue_op(KIND_PEEK, 1'b1, '0, '0, '0, 1'b0);
    queue_op(KIND_DEQ, 1'b1, '0, '0, '0, 1'b0);
    queue_op(KIND_LOOKUP, 1'b0, 32'h1, '0, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b1, 32'h1, 16'h10, '0, 1'b0);
    queue_op(KIND_RANGE, 1'b0, '0, 16'h0000, 16'hffff, 1'b0);
    // extremes, a duplicate tag and a taken priority
    queue_op(KIND_ENQ, 1'b0, 32'h0, 16'h0000, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b0, 32'hffff_ffff, 16'hffff, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b0, 32'h5a5a_a5a5, 16'h8000, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b0, 32'h5a5a_a5a5, 16'h1234, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b0, 32'h0000_0005, 16'h8000, '0, 1'b0);
    queue_op(KIND_LOOKUP, 1'b1, 32'h5a5a_a5a5, '0, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b1, 32'h5a5a_a5a5, 16'h4444, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b1, 32'hffff_ffff, 16'hffff, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b1, 32'hffff_ffff, 16'h0000, '0, 1'b0);
    queue_op(KIND_ENQ, 1'b1, 32'h0, 16'h7fff, '0, 1'b0);
    queue_op(KIND_PEEK, 1'b0, '0, '0, '0, 1'b0);
    queue_op(KIND_DEQ, 1'b0, '0, '0, '0, 1'b0);
    queue_op(KIND_RANGE, 1'b1, '0, 16'hffff, 16'h0000, 1'b0);
    queue_op(KIND_RANGE, 1'b0, '0, 16'h1000, 16'h7fff, 1'b0);
    queue_op(KIND_LOOKUP, 1'b0, 32'hdead_beef, '0, '0, 1'b0);
    queue_op(KIND_NOP_A, 1'b1, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b0);
    queue_op(KIND_NOP_B, 1'b0, '0, '0, '0, 1'b0);
    queue_op(KIND_CLEAR, 1'b1, '0, '0, '0, 1'b0);
    queue_op(KIND_PEEK, 1'b0, '0, '0, '0, 1'b0);

    // random phases; fill phases are weighted toward enqueues
    mode = MODE_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = mix_mode_t'($urandom_range(0, 2));
      queue_random_op(mode, (n % 300) == 150);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || offer_live) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // driver: holds an offered beat until it is taken
  always @(negedge clk) begin
    bit idle_now;
    if (!rst && !offer_live) begin
      idle_now = (beats_sent < NO_IDLE_FROM || beats_sent >= NO_IDLE_TO) &&
                 ($urandom_range(0, 99) < 25);
      if (cmd_backlog.size() != 0 && !idle_now &&
          !(cmd_backlog[0].hold_for_drain && (predicted_results.size() != 0 || busy))) begin
        cmd <= cmd_backlog[0].op;
        start <= 1'b1;
        offer_live = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // accept, predict and check
  always @(posedge clk) begin
    upq_out_t want;
    bit       active;
    active = 1'b0;
    if (!rst && start && !busy && offer_live) begin
      predicted_results.push_back(serve_op(cmd_backlog[0].op));
      void'(cmd_backlog.pop_front());
      offer_live = 1'b0;
      beats_sent++;
      active = 1'b1;
    end
    if (!rst && done) begin
      active = 1'b1;
      if (predicted_results.size() == 0) begin
        $error("result beat with nothing expected: %p", result);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("tag_out", 32'(want.tag_out), 32'(result.tag_out));
        check_field("prio_out", 32'(want.prio_out), 32'(result.prio_out));
        check_field("removed_count", 32'(want.removed_count), 32'(result.removed_count));
        check_field("fill_level", 32'(want.fill_level), 32'(result.fill_level));
        check_field("table_empty", 32'(want.table_empty), 32'(result.table_empty));
      end
    end
    quiet_cycles = active ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

[sim.f]
hdl/upq_pkg.sv
hdl/upq_ram.sv
hdl/upq_cmp.sv
hdl/unique_priority_queue_engine_core.sv
hdl/upq_checker.sv
test/testbench.sv
